>>> sv/typing_touchpad_lockout_defines.svh
// Assertion macros shared by the typing touchpad lockout RTL.
`ifndef TYPING_TOUCHPAD_LOCKOUT_DEFINES_SVH
`define TYPING_TOUCHPAD_LOCKOUT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define TTL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ttl_pkg.sv
// Package with types, register map and codes of the typing touchpad lockout.
package ttl_pkg;

  localparam int DEF_COUNT_BITS   = 16;
  localparam int DEF_MULTI_BUTTONS = 8;

  localparam int NUM_WORDS   = 4;
  localparam int WORD_BITS   = 64;
  localparam int IDLE_BITS   = 16;
  localparam int BTN_BITS    = 15;
  localparam int ADDR_BITS   = 6;
  localparam logic [IDLE_BITS-1:0] IDLE_RESET = 16'd100;

  typedef enum logic [2:0] {
    REG_MASK0  = 3'd0,
    REG_MASK1  = 3'd1,
    REG_MASK2  = 3'd2,
    REG_MASK3  = 3'd3,
    REG_IDLE   = 3'd4,
    REG_TAPS   = 3'd5,
    REG_COMBOS = 3'd6
  } reg_idx_t;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_ENABLE  = 2'd1;
  localparam logic [1:0] EV_DISABLE = 2'd2;

  localparam logic [1:0] OFF_ON   = 2'd0;
  localparam logic [1:0] OFF_ALL  = 2'd1;
  localparam logic [1:0] OFF_TAPS = 2'd2;

  typedef logic [NUM_WORDS-1:0][WORD_BITS-1:0] key_vec_t;

  typedef struct packed {
    key_vec_t             mask;
    logic [IDLE_BITS-1:0] idle_polls;
    logic                 taps_only;
    logic                 ignore_combos;
  } ttl_cfg_t;

endpackage

>>> sv/typing_touchpad_lockout.sv
// Top level of the typing touchpad lockout: poll register, decision logic, result register.
// A request accepted into the poll register passes on to the result register once that is free.
// Throughput: one request per cycle, set by the single step from the poll register to the
// result register; a held result stalls the input once the poll register is full.
// Reset (synchronous, active high) clears the pipeline, key history, primed flag and lock,
// saturates the idle counter and loads the register defaults.
module typing_touchpad_lockout
  import ttl_pkg::*;
#(
  parameter int COUNT_BITS    = DEF_COUNT_BITS,
  parameter int MULTI_BUTTONS = DEF_MULTI_BUTTONS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          keys0,
  input  logic [63:0]          keys1,
  input  logic [63:0]          keys2,
  input  logic [63:0]          keys3,
  input  logic [BTN_BITS-1:0]  pad_buttons,
  input  logic [1:0]           pad_off_now,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           event_res,
  output logic [1:0]           off_value,
  output logic                 locked_out
);

  `include "typing_touchpad_lockout_defines.svh"

  localparam int CMP_BITS = (COUNT_BITS > IDLE_BITS) ? COUNT_BITS : IDLE_BITS;
  localparam logic [BTN_BITS-1:0] BTN_MASK =
    BTN_BITS'(15'h700F | (((1 << MULTI_BUTTONS) - 1) << 4));
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  ttl_cfg_t cfg;

  ttl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Poll register.
  logic                s1_valid;
  key_vec_t            s1_keys;
  logic [BTN_BITS-1:0] s1_buttons;
  logic [1:0]          s1_off_now;

  // Block state.
  key_vec_t              prev_keys;
  logic                  primed;
  logic [COUNT_BITS-1:0] idle_count;
  logic                  locked;

  logic                  adv_out;
  logic                  active;
  logic                  combo;
  logic                  idle;
  logic [COUNT_BITS-1:0] idle_count_next;
  logic                  locked_next;
  logic [1:0]            ev_next;
  logic [1:0]            off_next;

  assign adv_out  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_keys    <= {keys3, keys2, keys1, keys0};
      s1_buttons <= pad_buttons;
      s1_off_now <= pad_off_now;
    end
  end

  always_comb begin
    active = 1'b0;
    combo  = 1'b0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      active = active || ((s1_keys[w] & ~prev_keys[w] & cfg.mask[w]) != '0);
      combo  = combo || ((s1_keys[w] & ~cfg.mask[w]) != '0);
    end
    if (cfg.ignore_combos && combo) begin
      active = 1'b0;
    end

    if (active) begin
      idle_count_next = '0;
    end else if (idle_count != COUNT_MAX) begin
      idle_count_next = idle_count + 1'b1;
    end else begin
      idle_count_next = idle_count;
    end
    if ((s1_buttons & BTN_MASK) != '0) begin
      idle_count_next = COUNT_MAX;
    end

    idle = (idle_count_next == COUNT_MAX) ||
           (CMP_BITS'(idle_count_next) > CMP_BITS'(cfg.idle_polls));

    ev_next     = EV_NONE;
    off_next    = OFF_ON;
    locked_next = locked;
    if (primed) begin
      if (idle) begin
        if (locked) begin
          locked_next = 1'b0;
          ev_next     = EV_ENABLE;
        end
      end else if (!locked && s1_off_now == OFF_ON) begin
        locked_next = 1'b1;
        ev_next     = EV_DISABLE;
        off_next    = cfg.taps_only ? OFF_TAPS : OFF_ALL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys  <= '0;
      primed     <= 1'b0;
      idle_count <= COUNT_MAX;
      locked     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (adv_out) begin
        prev_keys <= s1_keys;
        primed    <= 1'b1;
        locked    <= locked_next;
        if (primed) begin
          idle_count <= idle_count_next;
        end
      end
      if (adv_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      event_res  <= ev_next;
      off_value  <= off_next;
      locked_out <= locked_next;
    end
  end

  `TTL_ASSERT_SAME(a_enable_unlocks, clk, rst, out_valid && event_res == EV_ENABLE,
    !locked_out && off_value == OFF_ON, "enable result while still locked")
  `TTL_ASSERT_SAME(a_disable_locks, clk, rst, out_valid && event_res == EV_DISABLE,
    locked_out && (off_value == OFF_ALL || off_value == OFF_TAPS),
    "disable result without lock or off value")
  `TTL_ASSERT_NEXT(a_state_holds, clk, rst, !adv_out,
    $stable(locked) && $stable(idle_count) && $stable(primed),
    "state changed without a result being produced")
  `TTL_ASSERT_NEXT(a_first_poll_quiet, clk, rst, adv_out && !primed,
    event_res == EV_NONE && off_value == OFF_ON && !locked_out,
    "first poll produced an event")

endmodule

>>> sv/ttl_regs.sv
// Configuration register file of the typing touchpad lockout.
module ttl_regs
  import ttl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output ttl_cfg_t             cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask          <= '1;
      cfg.idle_polls    <= IDLE_RESET;
      cfg.taps_only     <= 1'b0;
      cfg.ignore_combos <= 1'b0;
    end else if (wr) begin
      unique case (idx) inside
        REG_MASK0, REG_MASK1, REG_MASK2, REG_MASK3: begin
          cfg.mask[paddr[4:3]] <= pwdata;
        end
        REG_IDLE:   cfg.idle_polls    <= pwdata[IDLE_BITS-1:0];
        REG_TAPS:   cfg.taps_only     <= pwdata[0];
        REG_COMBOS: cfg.ignore_combos <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx) inside
      REG_MASK0, REG_MASK1, REG_MASK2, REG_MASK3: prdata = cfg.mask[paddr[4:3]];
      REG_IDLE:   prdata = {{(64-IDLE_BITS){1'b0}}, cfg.idle_polls};
      REG_TAPS:   prdata = {63'd0, cfg.taps_only};
      REG_COMBOS: prdata = {63'd0, cfg.ignore_combos};
      default:    prdata = 64'd0;
    endcase
  end

endmodule

>>> test/typing_touchpad_lockout_test.sv
// Self-checking testbench for the typing touchpad lockout, with a predictor of its decisions.
`timescale 1ns / 1ps

module typing_touchpad_lockout_test;
  import ttl_pkg::*;

  localparam int CNT_BITS = DEF_COUNT_BITS;
  localparam int LIMIT = 400000;
  localparam int RX_HOLD = 400;
  localparam int IDLE_PCT = 36;
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    key_vec_t keys;
    logic [BTN_BITS-1:0] btn;
    logic [1:0] off_now;
  } poll_t;

  typedef struct packed {
    logic [1:0] ev;
    logic [1:0] offv;
    logic lk;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] keys0 = '0;
  logic [63:0] keys1 = '0;
  logic [63:0] keys2 = '0;
  logic [63:0] keys3 = '0;
  logic [BTN_BITS-1:0] pad_buttons = '0;
  logic [1:0] pad_off_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] event_res;
  logic [1:0] off_value;
  logic locked_out;

  typing_touchpad_lockout uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .keys0(keys0), .keys1(keys1), .keys2(keys2), .keys3(keys3),
    .pad_buttons(pad_buttons), .pad_off_now(pad_off_now),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .off_value(off_value), .locked_out(locked_out)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and verdicts owed by the block.
  poll_t poll_queue[$];
  verdict_t due_verdicts[$];
  poll_t on_offer;
  verdict_t got_due;

  ttl_cfg_t cfg_q;
  key_vec_t seen_keys;
  bit primed_q;
  logic [CNT_BITS-1:0] quiet_polls;
  bit lock_q;

  key_vec_t last_keys;
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit rx_hold_go = 1'b0;
  bit rx_hold_done = 1'b0;
  int rx_hold_cycles = 0;
  wire rx_holding = rx_hold_go && !rx_hold_done;

  function automatic verdict_t judge_poll(poll_t p);
    verdict_t v;
    bit active;
    bit combo;
    v = '{ev: EV_NONE, offv: OFF_ON, lk: 1'b0};
    active = 1'b0;
    combo = 1'b0;
    if (!primed_q) begin
      seen_keys = p.keys;
      primed_q = 1'b1;
    end else begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        if ((p.keys[w] & ~seen_keys[w] & cfg_q.mask[w]) != '0) active = 1'b1;
        if ((p.keys[w] & ~cfg_q.mask[w]) != '0) combo = 1'b1;
      end
      seen_keys = p.keys;
      if (cfg_q.ignore_combos && combo) active = 1'b0;
      if (active) quiet_polls = '0;
      else if (quiet_polls != '1) quiet_polls = quiet_polls + 1'b1;
      if (p.btn != '0) quiet_polls = '1;
      if (quiet_polls == '1 || quiet_polls > cfg_q.idle_polls) begin
        if (lock_q) begin
          lock_q = 1'b0;
          v.ev = EV_ENABLE;
          v.offv = OFF_ON;
        end
      end else if (!lock_q && p.off_now == OFF_ON) begin
        lock_q = 1'b1;
        v.ev = EV_DISABLE;
        v.offv = cfg_q.taps_only ? OFF_TAPS : OFF_ALL;
      end
    end
    v.lk = lock_q;
    return v;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  always @(posedge clk) begin
    if (rx_hold_go && !rx_hold_done) begin
      if (rx_hold_cycles == RX_HOLD) rx_hold_done <= 1'b1;
      else rx_hold_cycles <= rx_hold_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) due_verdicts.push_back(judge_poll(on_offer));
      if (!in_valid || in_ready) begin
        if (poll_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          on_offer = poll_queue.pop_front();
          keys0 <= on_offer.keys[0];
          keys1 <= on_offer.keys[1];
          keys2 <= on_offer.keys[2];
          keys3 <= on_offer.keys[3];
          pad_buttons <= on_offer.btn;
          pad_off_now <= on_offer.off_now;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: event %0d off %0d locked %0d",
                     event_res, off_value, locked_out);
        end else begin
          got_due = due_verdicts.pop_front();
          if (event_res !== got_due.ev || off_value !== got_due.offv ||
              locked_out !== got_due.lk) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: event %0d/%0d off %0d/%0d locked %0d/%0d (exp/got)",
                       got_due.ev, event_res, got_due.offv, off_value,
                       got_due.lk, locked_out);
          end
        end
      end
      out_ready <= rx_holding ? 1'b0 : (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_poll(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                           logic [63:0] k3, logic [BTN_BITS-1:0] btn, logic [1:0] off);
    poll_t p;
    p.keys[0] = k0;
    p.keys[1] = k1;
    p.keys[2] = k2;
    p.keys[3] = k3;
    p.btn = btn;
    p.off_now = off;
    last_keys = p.keys;
    poll_queue.push_back(p);
  endtask

  // Mostly typing-like changes to the previous snapshot, with some noise.
  task automatic add_random_polls(int n);
    key_vec_t k;
    logic [BTN_BITS-1:0] btn;
    logic [1:0] off;
    int r;
    for (int i = 0; i < n; i++) begin
      k = last_keys;
      r = $urandom_range(99);
      if (r < 45) begin
        k = last_keys;
      end else if (r < 70) begin
        k[$urandom_range(3)][$urandom_range(63)] = 1'b1;
      end else if (r < 90) begin
        k[$urandom_range(3)][$urandom_range(63)] = 1'b0;
      end else if (r < 95) begin
        for (int w = 0; w < NUM_WORDS; w++) k[w] = {$urandom, $urandom};
      end else if (r < 97) begin
        k = '0;
      end else begin
        k = '1;
      end
      r = $urandom_range(99);
      if (r < 88) btn = '0;
      else if (r < 96) btn = BTN_BITS'(1) << $urandom_range(BTN_BITS - 1);
      else btn = BTN_BITS'($urandom);
      off = ($urandom_range(99) < 75) ? 2'd0 : 2'($urandom_range(3));
      push_poll(k[0], k[1], k[2], k[3], btn, off);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(int'(idx) * 8);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MASK0, REG_MASK1, REG_MASK2, REG_MASK3: cfg_q.mask[idx[1:0]] = data;
      REG_IDLE: cfg_q.idle_polls = data[IDLE_BITS-1:0];
      REG_TAPS: cfg_q.taps_only = data[0];
      REG_COMBOS: cfg_q.ignore_combos = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                           logic [63:0] m3, logic [IDLE_BITS-1:0] idle, bit taps,
                           bit combos);
    write_reg(REG_MASK0, m0);
    write_reg(REG_MASK1, m1);
    write_reg(REG_MASK2, m2);
    write_reg(REG_MASK3, m3);
    write_reg(REG_IDLE, {48'($urandom), idle});
    write_reg(REG_TAPS, {63'($urandom), taps});
    write_reg(REG_COMBOS, {63'($urandom), combos});
  endtask

  function automatic logic [63:0] pick_mask();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [IDLE_BITS-1:0] pick_idle();
    case ($urandom_range(5))
      0: return '0;
      1: return IDLE_BITS'($urandom_range(3));
      2: return IDLE_BITS'($urandom_range(20));
      3: return IDLE_BITS'($urandom_range(120));
      4: return IDLE_BITS'(65534);
      default: return IDLE_BITS'($urandom_range(65534));
    endcase
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (poll_queue.size() != 0 || in_valid || due_verdicts.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    wait (cycles >= LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    cfg_q.mask = '1;
    cfg_q.idle_polls = IDLE_RESET;
    cfg_q.taps_only = 1'b0;
    cfg_q.ignore_combos = 1'b0;
    seen_keys = '0;
    primed_q = 1'b0;
    quiet_polls = '1;
    lock_q = 1'b0;
    last_keys = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // The first request only primes the key history.
    push_poll('1, '1, '1, '1, '0, 2'd0);
    push_poll('0, '0, '0, '0, '0, 2'd0);
    push_poll(64'd1, '0, '0, '0, '0, 2'd0);
    push_poll(64'd1, '0, '0, '0, '0, 2'd0);
    push_poll(64'd1, '0, '0, '0, 15'h4000, 2'd0);
    push_poll(64'd3, '0, '0, '0, '0, 2'd1);
    push_poll(64'd7, '0, '0, '0, '0, 2'd3);
    push_poll(64'd7, '0, '0, 64'h8000_0000_0000_0000, '0, 2'd2);
    push_poll(64'd7, '0, '0, 64'h8000_0000_0000_0000, 15'h0001, 2'd0);
    push_poll('0, '0, '0, '0, '0, 2'd0);
    push_poll('0, '1, '0, '0, '0, 2'd0);
    push_poll('1, '1, '1, '1, 15'h7FFF, 2'd0);
    drain();

    configure('0, '1, '1, '1, '0, 1'b1, 1'b1);
    write_reg(REG_NONE, '0);
    push_poll('0, '0, '0, '0, '0, 2'd0);
    push_poll('0, 64'd1, '0, '0, '0, 2'd0);
    push_poll('0, 64'd1, '0, '0, '0, 2'd0);
    push_poll(64'd1, 64'd3, '0, '0, '0, 2'd0);
    push_poll('0, 64'd7, '0, '0, '0, 2'd0);
    push_poll('0, 64'd7, '0, '0, '0, 2'd0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) configure('1, '1, '1, '1, IDLE_BITS'(65534), 1'b0, 1'b0);
      else if (ph == 1) configure('0, '0, '0, '0, IDLE_BITS'(2), 1'b1, 1'b1);
      else configure(pick_mask(), pick_mask(), pick_mask(), pick_mask(), pick_idle(),
                     1'($urandom), 1'($urandom));
      calm <= (ph == 2);
      if (ph == 3) begin
        // Keep the block fed while the receiver holds off.
        add_random_polls(150);
        rx_hold_go <= 1'b1;
        add_random_polls(50);
      end else if (ph == 4) begin
        add_random_polls(100);
        drain();
        add_random_polls(100);
      end else begin
        add_random_polls(200);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && due_verdicts.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/ttl_pkg.sv
sv/ttl_regs.sv
sv/typing_touchpad_lockout.sv
test/typing_touchpad_lockout_test.sv
